FILE: design/steepest_descent_2x2_solver_unit_assert.svh
`ifndef STEEPEST_DESCENT_2X2_SOLVER_UNIT_ASSERT_SVH
`define STEEPEST_DESCENT_2X2_SOLVER_UNIT_ASSERT_SVH
// clocked implication check
`define SDS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: check failed");
// next-cycle implication check
`define SDS_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: check failed");
`endif

FILE: design/sds_pkg.sv
package sds_pkg;

  typedef struct packed {
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
    logic signed [31:0] rhs1;
    logic signed [31:0] rhs2;
    logic signed [31:0] guess1;
    logic signed [31:0] guess2;
  } sds_in_t;

  typedef struct packed {
    logic signed [31:0] sol1;
    logic signed [31:0] sol2;
    logic [6:0]         iteration;
    logic               last;
    logic [1:0]         status;
  } sds_out_t;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_CONVERGED = 2'd1,
    ST_CAP       = 2'd2,
    ST_BREAKDOWN = 2'd3
  } sds_status_t;

  typedef enum logic [1:0] {
    CFG_TOLERANCE = 2'd0,
    CFG_MAX_ITER  = 2'd1
  } sds_cfg_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_AX1A, S_AX1B, S_AX2A, S_AX2B, S_RES,
    S_AR1A, S_AR1B, S_AR2A, S_AR2B, S_RR1, S_RR2, S_RAR1, S_RAR2,
    S_CHK, S_DIV, S_ST1, S_ST2, S_UPD, S_OUT
  } sds_state_t;

  localparam int IterLimit = 64;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: design/sds_divider.sv
// signed restoring divider: quotient of (num << 16) / den, toward zero, saturated
module sds_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  import sds_pkg::*;

  logic [47:0] rem;
  logic [47:0] dvd;
  logic [31:0] dvs;
  logic [47:0] q;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic [48:0] trial;
  logic signed [49:0] sq;

  assign trial = {rem, dvd[47]} - {17'd0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        dvd  <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
        dvs  <= den[31] ? 32'(-den) : 32'(den);
        neg  <= num[31] ^ den[31];
        q    <= '0;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial[47:0];
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[46:0], dvd[47]};
          q   <= {q[46:0], 1'b0};
        end
        dvd <= {dvd[46:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sq  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    quo = sat32(66'(sq));
  end

endmodule

FILE: design/steepest_descent_2x2_solver_unit.sv
// Per iteration: 13 sequenced multiply/add steps on one shared 32x32 multiplier, one check,
// the bit-serial divider, two step multiplies, the update and one output state; a breakdown
// iteration ends at the check and goes straight to output. An output stall holds the result
// in the output state.
// Operation: one solve at a time, up to 64 results per solve.
// Reset: synchronous, active high; tolerance 7, max_iterations 64, idle.
module steepest_descent_2x2_solver_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sds_pkg::sds_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sds_pkg::sds_out_t out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [30:0]       cfg_data
);
  import sds_pkg::*;

  sds_state_t state, state_next;
  logic [30:0] tol;
  logic [6:0]  max_iter;
  logic signed [31:0] a11, a12, a21, a22, b1, b2, x1, x2;
  logic signed [31:0] r1, r2, ar1, ar2, rr, rar, alpha, n1, n2, acc;
  logic [6:0] it, cap;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] qm;
  logic signed [31:0] qsum;
  logic signed [65:0] pr;

  logic div_start, div_done;
  logic signed [31:0] div_q;

  sds_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(rr), .den(rar),
    .done(div_done), .quo(div_q)
  );

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_AX1A: begin ma = a11; mb = x1; end
      S_AX1B: begin ma = a12; mb = x2; end
      S_AX2A: begin ma = a21; mb = x1; end
      S_AX2B: begin ma = a22; mb = x2; end
      S_AR1A: begin ma = a11; mb = r1; end
      S_AR1B: begin ma = a12; mb = r2; end
      S_AR2A: begin ma = a21; mb = r1; end
      S_AR2B: begin ma = a22; mb = r2; end
      S_RR1:  begin ma = r1;  mb = r1; end
      S_RR2:  begin ma = r2;  mb = r2; end
      S_RAR1: begin ma = r1;  mb = ar1; end
      S_RAR2: begin ma = r2;  mb = ar2; end
      S_ST1:  begin ma = alpha; mb = r1; end
      S_ST2:  begin ma = alpha; mb = r2; end
      default: ;
    endcase
    prod = ma * mb;
    pr   = 66'(prod) + 66'sd32768;
    qm   = sat32(pr >>> 16);
    qsum = sat32(66'(acc) + 66'(qm));
  end

  logic signed [32:0] d1, d2;
  logic [32:0] e1, e2, emax;
  logic conv;
  always_comb begin
    d1 = 33'(n1) - 33'(x1);
    d2 = 33'(n2) - 33'(x2);
    e1 = d1[32] ? 33'(-d1) : 33'(d1);
    e2 = d2[32] ? 33'(-d2) : 33'(d2);
    emax = (e1 > e2) ? e1 : e2;
    conv = emax < {2'b00, tol};
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      S_IDLE: if (in_valid) state_next = S_AX1A;
      S_AX1A: state_next = S_AX1B;
      S_AX1B: state_next = S_AX2A;
      S_AX2A: state_next = S_AX2B;
      S_AX2B: state_next = S_RES;
      S_RES:  state_next = S_AR1A;
      S_AR1A: state_next = S_AR1B;
      S_AR1B: state_next = S_AR2A;
      S_AR2A: state_next = S_AR2B;
      S_AR2B: state_next = S_RR1;
      S_RR1:  state_next = S_RR2;
      S_RR2:  state_next = S_RAR1;
      S_RAR1: state_next = S_RAR2;
      S_RAR2: state_next = S_CHK;
      S_CHK: begin
        if (rar == 0) state_next = S_OUT;
        else begin
          state_next = S_DIV;
          div_start  = 1'b1;
        end
      end
      S_DIV:  if (div_done) state_next = S_ST1;
      S_ST1:  state_next = S_ST2;
      S_ST2:  state_next = S_UPD;
      S_UPD:  state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = out_data.last ? S_IDLE : S_AX1A;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tol      <= 31'd7;
      max_iter <= 7'd64;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          1'(CFG_TOLERANCE): tol      <= cfg_data;
          1'(CFG_MAX_ITER):  max_iter <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) begin
        a11 <= in_data.a11; a12 <= in_data.a12;
        a21 <= in_data.a21; a22 <= in_data.a22;
        b1 <= in_data.rhs1; b2 <= in_data.rhs2;
        x1 <= in_data.guess1; x2 <= in_data.guess2;
        it <= '0;
        cap <= (max_iter == 7'd0) ? 7'd1 :
               (max_iter > 7'(IterLimit)) ? 7'(IterLimit) : max_iter;
        acc <= '0;
      end
      S_AX1A, S_AR1A, S_RR1, S_RAR1: acc <= qm;
      S_AX1B: begin r1 <= qsum; acc <= '0; end
      S_AX2B: r2 <= qsum;
      S_RES: begin
        r1 <= sat32(66'(b1) - 66'(r1));
        r2 <= sat32(66'(b2) - 66'(r2));
      end
      S_AR1B: ar1 <= qsum;
      S_AR2A: acc <= qm;
      S_AR2B: ar2 <= qsum;
      S_AX2A: acc <= qm;
      S_RR2:  rr  <= qsum;
      S_RAR2: rar <= qsum;
      S_CHK: if (rar == 0) begin
        out_data <= '{sol1: x1, sol2: x2, iteration: it, last: 1'b1,
                      status: ST_BREAKDOWN};
      end
      S_DIV: if (div_done) alpha <= div_q;
      S_ST1: n1 <= sat32(66'(x1) + 66'(qm));
      S_ST2: n2 <= sat32(66'(x2) + 66'(qm));
      S_UPD: begin
        x1 <= n1;
        x2 <= n2;
        if (conv)
          out_data <= '{sol1: n1, sol2: n2, iteration: it, last: 1'b1,
                        status: ST_CONVERGED};
        else if (it == cap - 7'd1)
          out_data <= '{sol1: n1, sol2: n2, iteration: it, last: 1'b1,
                        status: ST_CAP};
        else
          out_data <= '{sol1: n1, sol2: n2, iteration: it, last: 1'b0,
                        status: ST_RUNNING};
      end
      S_OUT: if (out_ready) begin
        it  <= it + 7'd1;
        acc <= '0;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/sds_checker.sv
`include "steepest_descent_2x2_solver_unit_assert.svh"
module sds_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sds_pkg::sds_out_t out_data
);
  import sds_pkg::*;

  // one solve at a time: never ready while a result is pending
  `SDS_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready)
  // a stalled result holds
  `SDS_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_data))
  // running status only on non-final results
  `SDS_ASSERT_IMP(a_stat, clk, rst, out_valid,
    (out_data.last == 1'b0) == (out_data.status == ST_RUNNING))
  // iteration stays under the 64-result limit
  `SDS_ASSERT_IMP(a_iter, clk, rst, out_valid, out_data.iteration < 7'd64)

endmodule

bind steepest_descent_2x2_solver_unit sds_checker u_sds_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
